// ===== rtl/ga_og_pkg.sv =====
// Shared types, constants and the sequencer control store for the
// offspring generator. No dependencies.
`timescale 1ns / 1ps

package ga_og_pkg;

   localparam int MUTABLE_WORDS = 4;
   localparam int WORD_BITS     = 16;
   localparam int WORD_IDX_W    = $clog2(MUTABLE_WORDS);
   localparam int MUT_DRAWS     = MUTABLE_WORDS * WORD_BITS;
   localparam int MUT_CNT_W     = $clog2(MUT_DRAWS);
   localparam int BIT_IDX_W     = $clog2(WORD_BITS);

   localparam logic [31:0] ZERO_SUB   = 32'h6D2B79F5;
   localparam logic [31:0] PPM_SCALE  = 32'd1000000;
   localparam logic [19:0] HALF_PPM   = 20'd500000;
   // floor(2^50 / 1e6); quotient is low by at most one
   localparam logic [30:0] RECIP_1E6  = 31'd1125899906;
   localparam int          RECIP_SHIFT = 50;
   localparam int          QUOT_W     = 13;
   localparam int          REM_W      = 21;
   localparam int          PPM_W      = 20;

   localparam logic [1:0] CSR_SEED      = 2'd0;
   localparam logic [1:0] CSR_CROSSOVER = 2'd1;
   localparam logic [1:0] CSR_MUTATION  = 2'd2;

   localparam int STEP_W = 5;

   typedef struct packed {
      logic [15:0] parent_a_node0;
      logic [15:0] parent_a_node1;
      logic [15:0] parent_a_node2;
      logic [15:0] parent_a_node3;
      logic [15:0] parent_b_node0;
      logic [15:0] parent_b_node1;
      logic [15:0] parent_b_node2;
      logic [15:0] parent_b_node3;
   } req_data_type;

   typedef struct packed {
      logic [15:0] child_node0;
      logic [15:0] child_node1;
      logic [15:0] child_node2;
      logic [15:0] child_node3;
      logic        did_crossover;
   } rsp_data_type;

   // what a draw is used for; KIND_NONE marks an empty pipeline slot
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_CROSS,
      KIND_HALF,
      KIND_MUT,
      KIND_PICK,
      KIND_BIT
   } draw_kind_type;

   typedef struct packed {
      draw_kind_type        kind;
      logic [MUT_CNT_W-1:0] idx;
   } draw_tag_type;

   typedef struct packed {
      draw_kind_type        kind;
      logic [MUT_CNT_W-1:0] idx;
      logic                 pass;
      logic [BIT_IDX_W-1:0] low;
   } draw_res_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_STEP,
      OP_LOOP,
      OP_BR_NOX,
      OP_BR_FLIP,
      OP_DONE
   } seq_op_type;

   typedef struct packed {
      seq_op_type            op;
      draw_kind_type         kind;
      logic [WORD_IDX_W-1:0] word;
      logic [STEP_W-1:0]     target;
   } ctrl_word_type;

   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_MUT  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_DONE = 5'd20;

   // control store; each branch sits behind plain steps that let the draw it tests
   // pass the s1, s2 and s3 pipeline registers and land in its flag register
   function automatic ctrl_word_type ctrl_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '{op: OP_STEP, kind: KIND_NONE, word: '0, target: STEP_IDLE};
      unique case (step)
         5'd0:  cw.op = OP_IDLE;
         5'd1:  cw.kind = KIND_CROSS;
         5'd2, 5'd3, 5'd4: cw.op = OP_STEP;
         5'd5:  begin
            cw.op     = OP_BR_NOX;
            cw.target = STEP_MUT;
         end
         5'd6:  begin cw.kind = KIND_HALF; cw.word = 2'd0; end
         5'd7:  begin cw.kind = KIND_HALF; cw.word = 2'd1; end
         5'd8:  begin cw.kind = KIND_HALF; cw.word = 2'd2; end
         5'd9:  begin cw.kind = KIND_HALF; cw.word = 2'd3; end
         5'd10: begin
            cw.op   = OP_LOOP;
            cw.kind = KIND_MUT;
         end
         5'd11, 5'd12, 5'd13: cw.op = OP_STEP;
         5'd14: begin
            cw.op     = OP_BR_FLIP;
            cw.target = STEP_DONE;
         end
         5'd15: cw.kind = KIND_PICK;
         5'd16: cw.kind = KIND_BIT;
         5'd17, 5'd18, 5'd19: cw.op = OP_STEP;
         5'd20: begin
            cw.op     = OP_DONE;
            cw.target = STEP_IDLE;
         end
         default: begin
            cw.op     = OP_DONE;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/ga_og_offspring_generator.sv =====
// Top level of the offspring generator: microcoded sequencer, child words,
// output register. Depends on ga_og_pkg and ga_og_draw_pipe.
`timescale 1ns / 1ps

// Builds one child per item from two parents' four 16-bit words: a
// crossover draw, four per-word parent draws when crossover is taken,
// 64 per-bit mutation draws and, if nothing flipped, two draws that pick
// one bit to flip. One item is worked at a time: the single xorshift
// generator makes at most one draw per cycle, and at each of the two
// branches the sequencer waits for the mod-1e6 pipeline to return the
// draw it tests and for it to land in a flag register. The result
// sits in an output register, so the next item is accepted while it waits.
// Writing csr index 0 reloads the generator state; indexes 1 and 2 set the
// crossover and per-bit mutation chance in parts per million.

module ga_offspring_generator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ga_og_pkg::req_data_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ga_og_pkg::rsp_data_type rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   logic [ga_og_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ga_og_pkg::MUT_CNT_W-1:0] mut_cnt_ff, mut_cnt_in;
   logic [ga_og_pkg::PPM_W-1:0]     cross_ppm_ff, mut_ppm_ff;
   logic [15:0] child_ff [ga_og_pkg::MUTABLE_WORDS];
   logic [15:0] par_b_ff [ga_og_pkg::MUTABLE_WORDS];
   logic        cross_ff, flipped_ff;
   logic [ga_og_pkg::WORD_IDX_W-1:0] pick_ff;
   logic        rsp_valid_ff;
   ga_og_pkg::rsp_data_type rsp_data_ff;

   ga_og_pkg::ctrl_word_type cw;
   ga_og_pkg::draw_tag_type  tag;
   ga_og_pkg::draw_res_type  res;
   logic accept, issue, done_fire, seed_load;

   assign cw        = ga_og_pkg::ctrl_rom(step_ff);
   assign req_ready = (cw.op == ga_og_pkg::OP_IDLE);
   assign accept    = req_valid && req_ready;
   assign done_fire = (cw.op == ga_og_pkg::OP_DONE) && (!rsp_valid_ff || rsp_ready);
   assign issue     = (cw.kind != ga_og_pkg::KIND_NONE);
   assign seed_load = csr_we && (csr_index == ga_og_pkg::CSR_SEED);

   always_comb begin
      tag.kind = cw.kind;
      tag.idx  = (cw.op == ga_og_pkg::OP_LOOP) ? mut_cnt_ff :
                 {{(ga_og_pkg::MUT_CNT_W-ga_og_pkg::WORD_IDX_W){1'b0}}, cw.word};
   end

   ga_og_draw_pipe u_draw (
      .clock        (clock),
      .reset        (reset),
      .seed_load    (seed_load),
      .seed_value   (csr_wdata),
      .issue        (issue),
      .issue_tag    (tag),
      .cross_chance (cross_ppm_ff),
      .flip_chance  (mut_ppm_ff),
      .res          (res)
   );

   // step sequencing
   always_comb begin
      step_in    = step_ff + 1'b1;
      mut_cnt_in = mut_cnt_ff;
      unique case (cw.op)
         ga_og_pkg::OP_IDLE: begin
            step_in    = accept ? step_ff + 1'b1 : step_ff;
            mut_cnt_in = '0;
         end
         ga_og_pkg::OP_STEP: step_in = step_ff + 1'b1;
         ga_og_pkg::OP_LOOP: begin
            mut_cnt_in = mut_cnt_ff + 1'b1;
            if (mut_cnt_ff != ga_og_pkg::MUT_CNT_W'(ga_og_pkg::MUT_DRAWS - 1)) begin
               step_in = step_ff;
            end
         end
         ga_og_pkg::OP_BR_NOX:  step_in = cross_ff ? step_ff + 1'b1 : cw.target;
         ga_og_pkg::OP_BR_FLIP: step_in = flipped_ff ? cw.target : step_ff + 1'b1;
         ga_og_pkg::OP_DONE:    step_in = done_fire ? cw.target : step_ff;
         default:               step_in = ga_og_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ga_og_pkg::STEP_IDLE;
         mut_cnt_ff   <= '0;
         cross_ppm_ff <= 20'd700000;
         mut_ppm_ff   <= 20'd30000;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         mut_cnt_ff <= mut_cnt_in;
         if (csr_we && (csr_index == ga_og_pkg::CSR_CROSSOVER)) begin
            cross_ppm_ff <= csr_wdata[ga_og_pkg::PPM_W-1:0];
         end
         if (csr_we && (csr_index == ga_og_pkg::CSR_MUTATION)) begin
            mut_ppm_ff <= csr_wdata[ga_og_pkg::PPM_W-1:0];
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // child words: loaded from parent A, then updated as draw results land
   always_ff @(posedge clock) begin
      if (accept) begin
         child_ff[0] <= req_data.parent_a_node0;
         child_ff[1] <= req_data.parent_a_node1;
         child_ff[2] <= req_data.parent_a_node2;
         child_ff[3] <= req_data.parent_a_node3;
         par_b_ff[0] <= req_data.parent_b_node0;
         par_b_ff[1] <= req_data.parent_b_node1;
         par_b_ff[2] <= req_data.parent_b_node2;
         par_b_ff[3] <= req_data.parent_b_node3;
         cross_ff    <= 1'b0;
         flipped_ff  <= 1'b0;
      end else begin
         case (res.kind)
            ga_og_pkg::KIND_CROSS: cross_ff <= res.pass;
            ga_og_pkg::KIND_HALF: begin
               if (!res.pass) begin
                  child_ff[res.idx[ga_og_pkg::WORD_IDX_W-1:0]] <=
                     par_b_ff[res.idx[ga_og_pkg::WORD_IDX_W-1:0]];
               end
            end
            ga_og_pkg::KIND_MUT: begin
               if (res.pass) begin
                  child_ff[res.idx[ga_og_pkg::MUT_CNT_W-1:ga_og_pkg::BIT_IDX_W]]
                     [res.idx[ga_og_pkg::BIT_IDX_W-1:0]] <=
                     ~child_ff[res.idx[ga_og_pkg::MUT_CNT_W-1:ga_og_pkg::BIT_IDX_W]]
                     [res.idx[ga_og_pkg::BIT_IDX_W-1:0]];
                  flipped_ff <= 1'b1;
               end
            end
            ga_og_pkg::KIND_PICK: pick_ff <= res.low[ga_og_pkg::WORD_IDX_W-1:0];
            ga_og_pkg::KIND_BIT: begin
               child_ff[pick_ff][res.low] <= ~child_ff[pick_ff][res.low];
            end
            default: begin
            end
         endcase
      end
      if (done_fire) begin
         rsp_data_ff.child_node0   <= child_ff[0];
         rsp_data_ff.child_node1   <= child_ff[1];
         rsp_data_ff.child_node2   <= child_ff[2];
         rsp_data_ff.child_node3   <= child_ff[3];
         rsp_data_ff.did_crossover <= cross_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ga_og_draw_pipe.sv =====
// Xorshift32 generator with a three-stage mod-1e6 pipeline and ppm compare.
// Depends on ga_og_pkg.
`timescale 1ns / 1ps

module ga_og_draw_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      seed_load,
   input  logic [31:0]               seed_value,
   input  logic                      issue,
   input  ga_og_pkg::draw_tag_type   issue_tag,
   input  logic [ga_og_pkg::PPM_W-1:0] cross_chance,
   input  logic [ga_og_pkg::PPM_W-1:0] flip_chance,
   output ga_og_pkg::draw_res_type   res
);

   logic [31:0] rng_ff, rng_in;
   logic [31:0] x0, x1, x2, x3;

   ga_og_pkg::draw_tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [31:0] s1_x_ff, s2_x_ff;
   logic [ga_og_pkg::QUOT_W-1:0] s2_q_ff, s2_q_in;
   logic [ga_og_pkg::PPM_W-1:0] s3_r_ff, s3_r_in;
   logic [ga_og_pkg::BIT_IDX_W-1:0] s3_low_ff;
   logic [62:0] prod;
   logic [31:0] qm, diff;
   logic [ga_og_pkg::REM_W-1:0] rem;
   logic [ga_og_pkg::REM_W-1:0] rem_fix;

   always_comb begin
      x0 = (rng_ff != 32'd0) ? rng_ff : ga_og_pkg::ZERO_SUB;
      x1 = x0 ^ (x0 << 13);
      x2 = x1 ^ (x1 >> 17);
      x3 = x2 ^ (x2 << 5);
      if (seed_load) begin
         rng_in = seed_value;
      end else if (issue) begin
         rng_in = x3;
      end else begin
         rng_in = rng_ff;
      end
   end

   // stage 1: reciprocal multiply for the quotient
   assign prod    = {31'd0, s1_x_ff} * {32'd0, ga_og_pkg::RECIP_1E6};
   assign s2_q_in = prod[ga_og_pkg::RECIP_SHIFT +: ga_og_pkg::QUOT_W];

   // stage 2: remainder, one correction
   assign qm      = {19'd0, s2_q_ff} * ga_og_pkg::PPM_SCALE;
   assign diff    = s2_x_ff - qm;
   assign rem     = diff[ga_og_pkg::REM_W-1:0];
   assign rem_fix = (rem >= ga_og_pkg::PPM_SCALE[ga_og_pkg::REM_W-1:0]) ?
                    rem - ga_og_pkg::PPM_SCALE[ga_og_pkg::REM_W-1:0] : rem;
   assign s3_r_in = rem_fix[ga_og_pkg::PPM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff    <= 32'd3;
         s1_tag_ff <= '{kind: ga_og_pkg::KIND_NONE, idx: '0};
         s2_tag_ff <= '{kind: ga_og_pkg::KIND_NONE, idx: '0};
         s3_tag_ff <= '{kind: ga_og_pkg::KIND_NONE, idx: '0};
      end else begin
         rng_ff    <= rng_in;
         s1_tag_ff <= issue ? issue_tag :
                      ga_og_pkg::draw_tag_type'{kind: ga_og_pkg::KIND_NONE, idx: '0};
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
      s1_x_ff   <= x3;
      s2_x_ff   <= s1_x_ff;
      s2_q_ff   <= s2_q_in;
      s3_r_ff   <= s3_r_in;
      s3_low_ff <= s2_x_ff[ga_og_pkg::BIT_IDX_W-1:0];
   end

   always_comb begin
      res.kind = s3_tag_ff.kind;
      res.idx  = s3_tag_ff.idx;
      res.low  = s3_low_ff;
      case (s3_tag_ff.kind)
         ga_og_pkg::KIND_CROSS: res.pass = s3_r_ff < cross_chance;
         ga_og_pkg::KIND_HALF:  res.pass = s3_r_ff < ga_og_pkg::HALF_PPM;
         ga_og_pkg::KIND_MUT:   res.pass = s3_r_ff < flip_chance;
         default:               res.pass = 1'b0;
      endcase
   end

endmodule

// ===== verif/ga_offspring_generator_test.sv =====
// Self-checking testbench for ga_offspring_generator: predicts each child from
// its own xorshift32 generator and configuration copy. Depends on ga_og_pkg and ga_offspring_generator.
`timescale 1ns / 1ps

module ga_offspring_generator_test;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;
   localparam logic [15:0] ONES        = 16'hFFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   ga_og_pkg::req_data_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   ga_og_pkg::rsp_data_type rsp_data;
   logic                   csr_we = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [31:0]            csr_wdata = '0;

   // predictor state, mirrors the block after reset
   logic [31:0] gen_state = 32'd3;
   logic [19:0] cross_ppm = 20'd700000;
   logic [19:0] mut_ppm   = 20'd30000;

   ga_og_pkg::req_data_type parent_queue[$];
   ga_og_pkg::rsp_data_type child_queue[$];
   bit           idle_on = 1'b1;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   ga_offspring_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] next_draw();
      logic [31:0] x;
      x = (gen_state != 32'd0) ? gen_state : ga_og_pkg::ZERO_SUB;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      gen_state = x;
      return x;
   endfunction

   function automatic logic draw_below(input logic [31:0] ppm);
      return (next_draw() % ga_og_pkg::PPM_SCALE) < ppm;
   endfunction

   function automatic ga_og_pkg::rsp_data_type predict_child(
         input ga_og_pkg::req_data_type p);
      logic [15:0]  pa[ga_og_pkg::MUTABLE_WORDS];
      logic [15:0]  pb[ga_og_pkg::MUTABLE_WORDS];
      logic [15:0]  ch[ga_og_pkg::MUTABLE_WORDS];
      logic         crossed;
      logic         flipped;
      int unsigned  pick;
      int unsigned  bitn;
      ga_og_pkg::rsp_data_type r;
      pa = '{p.parent_a_node0, p.parent_a_node1, p.parent_a_node2, p.parent_a_node3};
      pb = '{p.parent_b_node0, p.parent_b_node1, p.parent_b_node2, p.parent_b_node3};
      flipped = 1'b0;
      crossed = draw_below({12'd0, cross_ppm});
      for (int w = 0; w < ga_og_pkg::MUTABLE_WORDS; w++) begin
         ch[w] = pa[w];
         if (crossed) begin
            if (!draw_below({12'd0, ga_og_pkg::HALF_PPM})) ch[w] = pb[w];
         end
      end
      for (int w = 0; w < ga_og_pkg::MUTABLE_WORDS; w++) begin
         for (int b = 0; b < ga_og_pkg::WORD_BITS; b++) begin
            if (draw_below({12'd0, mut_ppm})) begin
               ch[w][b] = ~ch[w][b];
               flipped = 1'b1;
            end
         end
      end
      // nothing flipped: force a single flip at a drawn word and bit
      if (!flipped) begin
         pick = next_draw() % ga_og_pkg::MUTABLE_WORDS;
         bitn = next_draw() % ga_og_pkg::WORD_BITS;
         ch[pick][bitn] = ~ch[pick][bitn];
      end
      r.child_node0   = ch[0];
      r.child_node1   = ch[1];
      r.child_node2   = ch[2];
      r.child_node3   = ch[3];
      r.did_crossover = crossed;
      return r;
   endfunction

   function automatic ga_og_pkg::req_data_type pair_of(input logic [63:0] a,
                                                       input logic [63:0] b);
      return ga_og_pkg::req_data_type'({a, b});
   endfunction

   function automatic ga_og_pkg::req_data_type random_parents();
      logic [15:0] w[8];
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 9))
            0:       w[i] = 16'h0000;
            1:       w[i] = ONES;
            default: w[i] = 16'($urandom_range(0, 65535));
         endcase
      end
      // identical parents now and then
      if ($urandom_range(0, 7) == 0) begin
         for (int i = 0; i < 4; i++) w[i + 4] = w[i];
      end
      return pair_of({w[0], w[1], w[2], w[3]}, {w[4], w[5], w[6], w[7]});
   endfunction

   function automatic logic [31:0] random_ppm_word();
      logic [19:0] ppm;
      case ($urandom_range(0, 7))
         0:       ppm = 20'd0;
         1:       ppm = 20'd1000000;
         2:       ppm = 20'hFFFFF;
         3:       ppm = 20'($urandom_range(0, 1000000));
         default: ppm = 20'($urandom_range(0, 80000));
      endcase
      // junk above bit 19 must be dropped
      return {12'($urandom_range(0, 4095)), ppm};
   endfunction

   // sender: one item presented at a time, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            child_queue.push_back(predict_child(req_data));
            if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (parent_queue.size() != 0) begin
               req_data  <= parent_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each child against the oldest prediction
   always @(posedge clock) begin
      ga_og_pkg::rsp_data_type exp_child;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (child_queue.size() == 0) begin
               $error("child item with no prediction pending: %h", rsp_data);
               mismatch_count++;
            end else begin
               exp_child = child_queue.pop_front();
               if (rsp_data.child_node0 !== exp_child.child_node0) begin
                  $error("child_node0: expected %h, got %h",
                         exp_child.child_node0, rsp_data.child_node0);
                  mismatch_count++;
               end
               if (rsp_data.child_node1 !== exp_child.child_node1) begin
                  $error("child_node1: expected %h, got %h",
                         exp_child.child_node1, rsp_data.child_node1);
                  mismatch_count++;
               end
               if (rsp_data.child_node2 !== exp_child.child_node2) begin
                  $error("child_node2: expected %h, got %h",
                         exp_child.child_node2, rsp_data.child_node2);
                  mismatch_count++;
               end
               if (rsp_data.child_node3 !== exp_child.child_node3) begin
                  $error("child_node3: expected %h, got %h",
                         exp_child.child_node3, rsp_data.child_node3);
                  mismatch_count++;
               end
               if (rsp_data.did_crossover !== exp_child.did_crossover) begin
                  $error("did_crossover: expected %b, got %b",
                         exp_child.did_crossover, rsp_data.did_crossover);
                  mismatch_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 10);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // block is idle once nothing is queued, presented or outstanding
   task automatic settle();
      do @(negedge clock);
      while (parent_queue.size() != 0 || req_valid || child_queue.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         ga_og_pkg::CSR_SEED:      gen_state = value;
         ga_og_pkg::CSR_CROSSOVER: cross_ppm = value[19:0];
         ga_og_pkg::CSR_MUTATION:  mut_ppm   = value[19:0];
         default: ;
      endcase
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: seed 3, crossover 70%, mutation 3%
      parent_queue.push_back(pair_of(64'h0, 64'h0));
      parent_queue.push_back(pair_of({4{ONES}}, {4{ONES}}));
      parent_queue.push_back(pair_of(64'h0, {4{ONES}}));
      parent_queue.push_back(pair_of({4{ONES}}, 64'h0));
      parent_queue.push_back(pair_of(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
      settle();

      // zero seed, both chances zero: no crossover, one forced flip
      write_reg(ga_og_pkg::CSR_SEED, 32'd0);
      write_reg(ga_og_pkg::CSR_CROSSOVER, 32'd0);
      write_reg(ga_og_pkg::CSR_MUTATION, 32'd0);
      @(negedge clock);
      parent_queue.push_back(pair_of(64'h0, {4{ONES}}));
      parent_queue.push_back(pair_of({4{ONES}}, 64'h0));
      parent_queue.push_back(pair_of({4{16'hAAAA}}, {4{16'h5555}}));
      settle();

      // chances above one million: every crossover and mutation draw passes
      write_reg(ga_og_pkg::CSR_CROSSOVER, 32'h000FFFFF);
      write_reg(ga_og_pkg::CSR_MUTATION, 32'h000FFFFF);
      @(negedge clock);
      parent_queue.push_back(pair_of(64'h0, {4{ONES}}));
      parent_queue.push_back(pair_of({4{ONES}}, 64'h0));
      parent_queue.push_back(random_parents());
      settle();

      write_reg(ga_og_pkg::CSR_SEED, 32'hFFFFFFFF);
      write_reg(ga_og_pkg::CSR_CROSSOVER, 32'd1000000);
      write_reg(ga_og_pkg::CSR_MUTATION, 32'd1);
      @(negedge clock);
      parent_queue.push_back(pair_of(64'h0, {4{ONES}}));
      parent_queue.push_back(pair_of({4{16'h5555}}, {4{16'hAAAA}}));
      parent_queue.push_back(random_parents());
      settle();

      // unused index is ignored; high junk bits on a chance write
      write_reg(CSR_UNUSED, $urandom);
      write_reg(ga_og_pkg::CSR_CROSSOVER, 32'hFFF7A120);
      write_reg(ga_og_pkg::CSR_MUTATION, 32'h00007530);
      @(negedge clock);
      parent_queue.push_back(random_parents());
      parent_queue.push_back(random_parents());
      parent_queue.push_back(random_parents());
      settle();

      for (int phase = 0; phase < 9; phase++) begin
         if ($urandom_range(0, 3) != 0)
            write_reg(ga_og_pkg::CSR_SEED,
                      ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom));
         write_reg(ga_og_pkg::CSR_CROSSOVER, random_ppm_word());
         write_reg(ga_og_pkg::CSR_MUTATION, random_ppm_word());
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, $urandom);
         @(negedge clock);
         // last phase runs with no idling at all
         idle_on = (phase < 8) && (phase % 3 != 2);
         for (int i = 0; i < ((phase < 8) ? 150 : 100); i++)
            parent_queue.push_back(random_parents());
         settle();
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
